### sv/swdhte_pkg.sv
`timescale 1ns / 1ps

package swdhte_pkg;

    // request codes carried in the op field
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_FLUSH = 2'd3;

    // ack codes as sampled from the line
    localparam logic [2:0] ACK_OK    = 3'd1;
    localparam logic [2:0] ACK_WAIT  = 3'd2;
    localparam logic [2:0] ACK_FAULT = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PARITY  = 2'd1;
    localparam logic [1:0] ST_FAULT   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // start and park bits forced into every request header
    localparam logic [7:0] HDR_FORCE_BITS = 8'h81;
    // automatic DP ABORT write
    localparam logic [7:0]  ABORT_HEADER = 8'h00;
    localparam logic [31:0] ABORT_DATA   = 32'h0000_001E;

    localparam logic [7:0] HDR_LEN_READ  = 8'd12;
    localparam logic [7:0] HDR_LEN_WRITE = 8'd13;
    localparam logic [7:0] HDR_BITS      = 8'd8;
    localparam logic [7:0] ACK_FIRST     = 8'd9;
    localparam logic [7:0] ACK_MID       = 8'd10;
    localparam logic [7:0] ACK_LAST      = 8'd11;
    localparam logic [7:0] DATA_BITS     = 8'd32;
    localparam logic [7:0] FLUSH_BITS    = 8'd8;

    // configuration register addresses
    localparam int unsigned  ADDR_W          = 3;
    localparam logic [ADDR_W-1:0] ADDR_AP_DELAY = 3'd0;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_DATA,
        PH_TAIL,
        PH_DELAY,
        PH_FLUSH
    } t_phase;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  header;
        logic [31:0] write_data;
        logic        line_in;
    } t_swd_in;

    typedef struct packed {
        logic        clock_pulse;
        logic        line_out;
        logic        busy_res;
        logic        read_valid;
        logic [31:0] read_data;
        logic        flush_done;
        logic [1:0]  status;
    } t_swd_out;

endpackage

### sv/swd_host_transaction_engine_top.sv
`timescale 1ns / 1ps

// Bit-level SWD host. A read or write transaction arms a request and every
// later tick transaction clocks one SWD bit, LSB first; each input
// transaction yields exactly one result transaction. The block takes one
// transaction per clock while the result side is not stalled: it passes
// through an input register, is worked on by the combinational bit engine
// and lands in a result register. Both registers advance together
// whenever the result register is empty or being taken, so the input
// register can still take one transaction while a finished result waits.
// WAIT acks launch a DP ABORT write on their own; ap_delay_clocks
// (APB, offset 0) adds idle clocks after an OK access-port transaction.
// Write configuration only while the engine is idle.
module swd_host_transaction_engine_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input transactions
    input  logic                          i_in_valid,
    input  swdhte_pkg::t_swd_in           i_in_data,
    output logic                          o_in_stall,
    // result transactions
    output logic                          o_out_valid,
    output swdhte_pkg::t_swd_out          o_out_data,
    input  logic                          i_out_stall,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swdhte_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // configuration
    logic [7:0] r_ap_delay;

    // pipeline registers
    logic                 r_in_valid;
    swdhte_pkg::t_swd_in  r_in;
    logic                 r_out_valid;
    swdhte_pkg::t_swd_out r_out;
    logic                 w_advance;
    logic                 w_accept;

    // engine state
    swdhte_pkg::t_phase r_phase,      n_phase;
    logic [7:0]         r_bit_count,  n_bit_count;
    logic [7:0]         r_header,     n_header;
    logic [31:0]        r_data_shift, n_data_shift;
    logic [2:0]         r_ack,        n_ack;
    logic               r_parity,     n_parity;
    logic               r_abort_pend, n_abort_pend;
    logic [1:0]         r_status,     n_status;
    logic               r_dir_read,   n_dir_read;
    logic [31:0]        r_held_read,  n_held_read;
    swdhte_pkg::t_swd_out n_out;

    // apb: always ready, single register
    assign pready = 1'b1;
    assign prdata = (paddr == swdhte_pkg::ADDR_AP_DELAY) ? {24'd0, r_ap_delay} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ap_delay <= 8'd0;
        end else if (psel && penable && pwrite && pready &&
                     paddr == swdhte_pkg::ADDR_AP_DELAY) begin
            r_ap_delay <= pwdata[7:0];
        end
    end

    // handshake: both stages move when the result register frees up
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= r_in_valid;
                r_in_valid  <= w_accept;
            end else if (w_accept) begin
                r_in_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (w_advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // engine state only moves when the transaction in the input register
    // is handed over to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= swdhte_pkg::PH_IDLE;
            r_bit_count  <= 8'd0;
            r_header     <= 8'd0;
            r_data_shift <= 32'd0;
            r_ack        <= 3'd0;
            r_parity     <= 1'b0;
            r_abort_pend <= 1'b0;
            r_status     <= swdhte_pkg::ST_OK;
            r_dir_read   <= 1'b0;
            r_held_read  <= 32'd0;
        end else if (w_advance && r_in_valid) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_header     <= n_header;
            r_data_shift <= n_data_shift;
            r_ack        <= n_ack;
            r_parity     <= n_parity;
            r_abort_pend <= n_abort_pend;
            r_status     <= n_status;
            r_dir_read   <= n_dir_read;
            r_held_read  <= n_held_read;
        end
    end

    // bit engine: next state and result for the registered transaction
    always_comb begin
        logic       clk_bit;
        logic       drv;
        logic       rvalid;
        logic       fdone;
        logic [7:0] hdr_len;
        logic [7:0] bc_inc;

        clk_bit = 1'b0;
        drv     = 1'b0;
        rvalid  = 1'b0;
        fdone   = 1'b0;
        hdr_len = r_dir_read ? swdhte_pkg::HDR_LEN_READ : swdhte_pkg::HDR_LEN_WRITE;
        bc_inc  = r_bit_count + 8'd1;

        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_header     = r_header;
        n_data_shift = r_data_shift;
        n_ack        = r_ack;
        n_parity     = r_parity;
        n_abort_pend = r_abort_pend;
        n_status     = r_status;
        n_dir_read   = r_dir_read;
        n_held_read  = r_held_read;

        if (r_phase == swdhte_pkg::PH_IDLE) begin
            case (r_in.op)
                swdhte_pkg::OP_READ: begin
                    n_header     = r_in.header | swdhte_pkg::HDR_FORCE_BITS;
                    n_data_shift = 32'd0;
                    n_parity     = 1'b0;
                    n_dir_read   = 1'b1;
                    n_ack        = 3'd0;
                    n_bit_count  = 8'd0;
                    n_phase      = swdhte_pkg::PH_HDR;
                end
                swdhte_pkg::OP_WRITE: begin
                    n_header     = r_in.header | swdhte_pkg::HDR_FORCE_BITS;
                    n_data_shift = r_in.write_data;
                    n_parity     = ^r_in.write_data;
                    n_dir_read   = 1'b0;
                    n_ack        = 3'd0;
                    n_bit_count  = 8'd0;
                    n_phase      = swdhte_pkg::PH_HDR;
                end
                swdhte_pkg::OP_FLUSH: begin
                    n_bit_count = 8'd0;
                    n_phase     = swdhte_pkg::PH_FLUSH;
                end
                default: begin
                    // tick while idle does nothing
                end
            endcase
        end else if (r_in.op == swdhte_pkg::OP_TICK) begin
            clk_bit = 1'b1;
            case (r_phase)
                swdhte_pkg::PH_HDR: begin
                    if (r_bit_count < swdhte_pkg::HDR_BITS) begin
                        drv = r_header[r_bit_count[2:0]];
                    end
                    // ack sampled on bits nine to eleven
                    if (r_bit_count == swdhte_pkg::ACK_FIRST) begin
                        n_ack[0] = r_ack[0] | r_in.line_in;
                    end
                    if (r_bit_count == swdhte_pkg::ACK_MID) begin
                        n_ack[1] = r_ack[1] | r_in.line_in;
                    end
                    if (r_bit_count == swdhte_pkg::ACK_LAST) begin
                        n_ack[2] = r_ack[2] | r_in.line_in;
                    end
                    n_bit_count = bc_inc;
                    if (bc_inc >= hdr_len) begin
                        n_bit_count = 8'd0;
                        n_phase     = swdhte_pkg::PH_DATA;
                    end
                end
                swdhte_pkg::PH_DATA: begin
                    if (r_dir_read) begin
                        n_data_shift = {r_in.line_in, r_data_shift[31:1]};
                    end else begin
                        drv          = r_data_shift[0];
                        n_data_shift = {1'b0, r_data_shift[31:1]};
                    end
                    n_bit_count = bc_inc;
                    if (bc_inc >= swdhte_pkg::DATA_BITS) begin
                        n_bit_count = 8'd0;
                        n_phase     = swdhte_pkg::PH_TAIL;
                    end
                end
                swdhte_pkg::PH_TAIL: begin
                    if (r_bit_count == 8'd0) begin
                        // parity bit
                        if (r_dir_read) begin
                            n_parity = r_in.line_in;
                        end else begin
                            drv = r_parity;
                        end
                        n_bit_count = 8'd1;
                    end else begin
                        // turnaround or trailing zero, then judge the ack
                        n_bit_count = 8'd0;
                        n_phase     = swdhte_pkg::PH_IDLE;
                        case (r_ack)
                            swdhte_pkg::ACK_OK: begin
                                n_abort_pend = 1'b0;
                                if (r_dir_read && (r_parity != ^r_data_shift)) begin
                                    n_status = swdhte_pkg::ST_PARITY;
                                end else begin
                                    if (r_dir_read) begin
                                        n_held_read = r_data_shift;
                                        rvalid      = 1'b1;
                                    end
                                    // access-port transactions get idle clocks
                                    if (r_header[1] && r_ap_delay != 8'd0) begin
                                        n_bit_count = r_ap_delay;
                                        n_phase     = swdhte_pkg::PH_DELAY;
                                    end
                                end
                            end
                            swdhte_pkg::ACK_WAIT: begin
                                n_abort_pend = 1'b1;
                                n_header     = swdhte_pkg::ABORT_HEADER |
                                               swdhte_pkg::HDR_FORCE_BITS;
                                n_data_shift = swdhte_pkg::ABORT_DATA;
                                n_parity     = ^swdhte_pkg::ABORT_DATA;
                                n_dir_read   = 1'b0;
                                n_ack        = 3'd0;
                                n_bit_count  = 8'd0;
                                n_phase      = swdhte_pkg::PH_HDR;
                            end
                            swdhte_pkg::ACK_FAULT: begin
                                n_abort_pend = 1'b0;
                                n_status     = swdhte_pkg::ST_FAULT;
                            end
                            default: begin
                                n_abort_pend = 1'b0;
                                n_status     = swdhte_pkg::ST_INVALID;
                            end
                        endcase
                    end
                end
                swdhte_pkg::PH_DELAY: begin
                    if (r_bit_count <= 8'd1) begin
                        n_bit_count = 8'd0;
                        n_phase     = swdhte_pkg::PH_IDLE;
                    end else begin
                        n_bit_count = r_bit_count - 8'd1;
                    end
                end
                swdhte_pkg::PH_FLUSH: begin
                    n_bit_count = bc_inc;
                    if (bc_inc >= swdhte_pkg::FLUSH_BITS) begin
                        n_bit_count = 8'd0;
                        n_phase     = swdhte_pkg::PH_IDLE;
                        fdone       = 1'b1;
                    end
                end
                default: begin
                    clk_bit     = 1'b0;
                    n_bit_count = 8'd0;
                    n_phase     = swdhte_pkg::PH_IDLE;
                end
            endcase
        end

        // status includes this transaction's outcome
        n_out.status = n_status;

        // flush reports the status it clears
        if (fdone) begin
            n_status = swdhte_pkg::ST_OK;
        end

        n_out.clock_pulse = clk_bit;
        n_out.line_out    = drv;
        n_out.busy_res    = (n_phase != swdhte_pkg::PH_IDLE);
        n_out.read_valid  = rvalid;
        n_out.read_data   = n_held_read;
        n_out.flush_done  = fdone;
    end

endmodule
